@@ sv/fas_pkg.sv @@
package fas_pkg;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_SUB  = 2'd1;
    localparam logic [1:0] KIND_MUL  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int MagW  = 58;
    localparam int MantW = 53;
    localparam int ExpW  = 11;

    localparam logic [31:0] SGL_QUIET       = 32'h0040_0000;
    localparam logic [31:0] SGL_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [30:0] SGL_INF         = 31'h7F80_0000;

    typedef struct packed {
        logic                   valid;
        logic                   special;
        logic [31:0]            spec_word;
        logic                   zero;
        logic                   sign;
        logic signed [ExpW-1:0] exp;
        logic [MantW-1:0]       mant;
    } fas_rnd_t;

    function automatic logic [5:0] fas_lzc(input logic [MagW-1:0] v);
        logic [5:0] n;
        n = 6'(MagW - 1);
        for (int i = 0; i < MagW; i++)
        begin
            if (v[i])
            begin
                n = 6'(MagW - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/float_add_sub_mul_truncating_core.sv @@
// Single-precision add, subtract and multiply with a chopped export.
// Input transaction: kind, operand_a, operand_b under in_valid/in_ready.
// kind 0 adds, 1 subtracts operand_b from operand_a, 2 multiplies, 3 gives +0.
// Output transaction: result_word under out_valid/out_ready.
// The exact result is rounded to 53 bits nearest-even, then chopped to a
// single when its exponent is normal, otherwise rounded nearest-even.
// Five register stages lie between acceptance and out_valid: operand decode and
// multiply, alignment and add, leading-zero normalize, 53-bit rounding,
// single export. Throughput is one transaction per cycle while the output is not held.
// The five stages advance together; when out_valid is high and out_ready is
// low the whole pipe holds and in_ready drops, so nothing is lost or repeated.
// Reset clears every stage valid bit; the block keeps no other state.
module float_add_sub_mul_truncating_core
    import fas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_word
);

    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // stage 1 decode
    logic       sa, sb, sbe, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] effa, effb, big_e, small_e, diff8;
    logic [23:0] siga, sigb, big_s, small_s;
    logic        swap;
    logic [31:0] spec_word;
    logic        special;
    logic        is_mul;

    assign sa     = operand_a[31];
    assign sb     = operand_b[31];
    assign sbe    = sb ^ (kind == KIND_SUB);
    assign a_nan  = (operand_a[30:23] == 8'hFF) && (operand_a[22:0] != 23'd0);
    assign b_nan  = (operand_b[30:23] == 8'hFF) && (operand_b[22:0] != 23'd0);
    assign a_inf  = (operand_a[30:23] == 8'hFF) && (operand_a[22:0] == 23'd0);
    assign b_inf  = (operand_b[30:23] == 8'hFF) && (operand_b[22:0] == 23'd0);
    assign a_zero = operand_a[30:0] == 31'd0;
    assign b_zero = operand_b[30:0] == 31'd0;
    assign effa   = (operand_a[30:23] == 8'd0) ? 8'd1 : operand_a[30:23];
    assign effb   = (operand_b[30:23] == 8'd0) ? 8'd1 : operand_b[30:23];
    assign siga   = {operand_a[30:23] != 8'd0, operand_a[22:0]};
    assign sigb   = {operand_b[30:23] != 8'd0, operand_b[22:0]};
    assign swap   = (effb > effa) || ((effb == effa) && (sigb > siga));
    assign big_e  = swap ? effb : effa;
    assign small_e = swap ? effa : effb;
    assign big_s  = swap ? sigb : siga;
    assign small_s = swap ? siga : sigb;
    assign diff8  = big_e - small_e;
    assign is_mul = kind == KIND_MUL;

    always_comb
    begin
        special   = 1'b1;
        spec_word = 32'd0;
        if (kind == KIND_NONE)
        begin
            spec_word = 32'd0;
        end else if (a_nan)
        begin
            spec_word = operand_a | SGL_QUIET;
        end else if (b_nan)
        begin
            spec_word = operand_b | SGL_QUIET;
        end else if (is_mul)
        begin
            if ((a_inf && b_zero) || (a_zero && b_inf))
            begin
                spec_word = SGL_DEFAULT_NAN;
            end else if (a_inf || b_inf)
            begin
                spec_word = {sa ^ sb, SGL_INF};
            end else
            begin
                special = 1'b0;
            end
        end else
        begin
            if (a_inf && b_inf && (sa != sbe))
            begin
                spec_word = SGL_DEFAULT_NAN;
            end else if (a_inf)
            begin
                spec_word = {sa, SGL_INF};
            end else if (b_inf)
            begin
                spec_word = {sbe, SGL_INF};
            end else
            begin
                special = 1'b0;
            end
        end
    end

    logic                   s1_valid_reg;
    logic                   s1_special_reg;
    logic [31:0]            s1_word_reg;
    logic                   s1_mul_reg;
    logic                   s1_sub_reg;
    logic                   s1_sign_reg;
    logic                   s1_zsign_reg;
    logic [23:0]            s1_big_reg;
    logic [23:0]            s1_small_reg;
    logic [5:0]             s1_diff_reg;
    logic signed [ExpW-1:0] s1_scale_reg;
    logic [47:0]            s1_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_special_reg <= special;
            s1_word_reg    <= spec_word;
            s1_mul_reg     <= is_mul;
            s1_sub_reg     <= sa ^ sbe;
            s1_sign_reg    <= is_mul ? (sa ^ sb) : (swap ? sbe : sa);
            s1_zsign_reg   <= is_mul ? (sa ^ sb) : (sa & sbe);
            s1_big_reg     <= big_s;
            s1_small_reg   <= small_s;
            s1_diff_reg    <= (diff8 > 8'd63) ? 6'd63 : diff8[5:0];
            s1_scale_reg   <= is_mul
                ? (ExpW'(effa) + ExpW'(effb) - ExpW'(310))
                : (ExpW'(big_e) - ExpW'(183));
            s1_prod_reg    <= siga * sigb;
        end
    end

    // stage 2 align and add, or take the product
    logic [2*MagW-1:0] small_wide;
    logic [MagW-1:0]   small_al;
    logic [MagW-1:0]   big_al;
    logic [MagW-1:0]   mag;

    assign small_wide = {1'b0, s1_small_reg, 33'd0, {MagW{1'b0}}} >> s1_diff_reg;
    assign small_al   = {small_wide[2*MagW-1:MagW+1],
                         small_wide[MagW] | (|small_wide[MagW-1:0])};
    assign big_al     = {1'b0, s1_big_reg, 33'd0};
    assign mag        = s1_mul_reg ? {s1_prod_reg, 10'd0}
                      : (s1_sub_reg ? big_al - small_al : big_al + small_al);

    logic                   s2_valid_reg;
    logic                   s2_special_reg;
    logic [31:0]            s2_word_reg;
    logic                   s2_sign_reg;
    logic                   s2_zsign_reg;
    logic signed [ExpW-1:0] s2_scale_reg;
    logic [MagW-1:0]        s2_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_special_reg <= s1_special_reg;
            s2_word_reg    <= s1_word_reg;
            s2_sign_reg    <= s1_sign_reg;
            s2_zsign_reg   <= s1_zsign_reg;
            s2_scale_reg   <= s1_scale_reg;
            s2_mag_reg     <= mag;
        end
    end

    // stage 3 normalize
    logic [5:0] lz;
    assign lz = fas_lzc(s2_mag_reg);

    logic                   s3_valid_reg;
    logic                   s3_special_reg;
    logic [31:0]            s3_word_reg;
    logic                   s3_zero_reg;
    logic                   s3_sign_reg;
    logic signed [ExpW-1:0] s3_exp_reg;
    logic [MagW-1:0]        s3_norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_special_reg <= s2_special_reg;
            s3_word_reg    <= s2_word_reg;
            s3_zero_reg    <= s2_mag_reg == '0;
            s3_sign_reg    <= (s2_mag_reg == '0) ? s2_zsign_reg : s2_sign_reg;
            s3_exp_reg     <= s2_scale_reg + ExpW'(MagW - 1) - ExpW'(lz);
            s3_norm_reg    <= s2_mag_reg << lz;
        end
    end

    // stage 4 round to 53 bits
    logic             rguard;
    logic             rsticky;
    logic [MantW:0]   mant_inc;
    fas_rnd_t         rnd_next;
    fas_rnd_t         s4_reg;

    assign rguard   = s3_norm_reg[4];
    assign rsticky  = |s3_norm_reg[3:0];
    assign mant_inc = {1'b0, s3_norm_reg[MagW-1:5]}
                    + (MantW+1)'(rguard && (rsticky || s3_norm_reg[5]));

    always_comb
    begin
        rnd_next.valid     = s3_valid_reg;
        rnd_next.special   = s3_special_reg;
        rnd_next.spec_word = s3_word_reg;
        rnd_next.zero      = s3_zero_reg;
        rnd_next.sign      = s3_sign_reg;
        if (mant_inc[MantW])
        begin
            rnd_next.mant = {1'b1, {(MantW-1){1'b0}}};
            rnd_next.exp  = s3_exp_reg + ExpW'(1);
        end else
        begin
            rnd_next.mant = mant_inc[MantW-1:0];
            rnd_next.exp  = s3_exp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg <= '0;
        end else if (advance)
        begin
            s4_reg <= rnd_next;
        end
    end

    // stage 5 export
    fas_export u_export (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rnd       (s4_reg),
        .valid_reg (out_valid),
        .word_reg  (result_word)
    );

endmodule

@@ sv/fas_export.sv @@
module fas_export
    import fas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  fas_rnd_t    rnd,
    output logic        valid_reg,
    output logic [31:0] word_reg
);

    logic signed [ExpW-1:0] sexp;
    logic signed [ExpW-1:0] shift_full;
    logic [5:0]             shift;
    logic [2*MantW-1:0]     wide;
    logic [MantW-1:0]       r;
    logic                   guard;
    logic                   sticky;
    logic [MantW-1:0]       r_rnd;
    logic [31:0]            word_next;

    assign sexp       = rnd.exp + ExpW'(127);
    assign shift_full = ExpW'(30) - sexp;
    assign shift      = shift_full[5:0];
    assign wide       = {rnd.mant, {MantW{1'b0}}} >> shift;
    assign r          = wide[2*MantW-1:MantW];
    assign guard      = wide[MantW-1];
    assign sticky     = |wide[MantW-2:0];
    assign r_rnd      = r + MantW'(guard && (sticky || r[0]));

    always_comb
    begin
        if (rnd.special) begin
            word_next = rnd.spec_word;
        end else if (rnd.zero) begin
            word_next = {rnd.sign, 31'd0};
        end else if (sexp >= ExpW'(255)) begin
            word_next = {rnd.sign, SGL_INF};
        end else if (sexp >= ExpW'(1)) begin
            word_next = {rnd.sign, sexp[7:0], rnd.mant[51:29]};
        end else if (shift_full > ExpW'(53)) begin
            word_next = {rnd.sign, 31'd0};
        end else begin
            word_next = {rnd.sign, r_rnd[30:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= rnd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            word_reg <= word_next;
        end
    end

endmodule
